@@ hdl/mecanum_wheel_mixer_assert.svh @@
// mecanum_wheel_mixer_assert.svh: assertion macros for the wheel mixer
// needs clk and rst_n in the scope of every use; no other dependencies
`ifndef MECANUM_WHEEL_MIXER_ASSERT_SVH
`define MECANUM_WHEEL_MIXER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, sampled on the rising clock edge
`define MWM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mecanum_wheel_mixer: check failed");

// next-cycle implication
`define MWM_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mecanum_wheel_mixer: check failed");

`else

`define MWM_ASSERT_IMP(name, ante, cons)

`define MWM_ASSERT_NXT(name, ante, cons)

`endif

`endif

@@ hdl/mwm_pkg.sv @@
// mwm_pkg: widths, fixed-point constants and shared types of the wheel mixer
// no dependencies; used by mwm_div_pipe and mecanum_wheel_mixer
package mwm_pkg;

    localparam int LANES      = 4;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;
    localparam int SUM_W      = IN_W + 1;
    localparam int COEF_W     = 30;
    localparam int RAW_W      = 48;
    localparam int MAG_W      = RAW_W - 1;
    localparam int W_SHIFT    = 30;
    localparam int ONE_SHIFT  = 42;
    localparam int QUO_W      = 17;
    localparam int DIV_STEPS  = QUO_W;

    // 1/sqrt2 in Q.30, rounded to nearest
    localparam logic signed [COEF_W:0] INV_SQRT2_Q30 = 31'sd759250125;

    // 1.0 in Q.42, the floor of the divisor
    localparam logic [MAG_W-1:0] ONE_Q42 =
        {{(MAG_W-ONE_SHIFT-1){1'b0}}, 1'b1, {ONE_SHIFT{1'b0}}};

    // largest quotient of |raw| * 2^16 / divisor, reached when |raw| equals the divisor
    localparam logic [QUO_W-1:0] QUO_LIMIT = {1'b1, {(QUO_W-1){1'b0}}};

    // positive full scale of a Q1.15 output
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};

    typedef logic [MAG_W-1:0] mag_t;
    typedef logic [LANES-1:0][MAG_W-1:0] mag_lanes_t;
    typedef logic [LANES-1:0][QUO_W-1:0] quo_lanes_t;

    // flow control and sign bits that travel beside the divider lanes
    typedef struct packed {
        logic             valid;
        logic [LANES-1:0] neg;
    } lane_ctl_t;

endpackage

@@ hdl/mwm_div_pipe.sv @@
// mwm_div_pipe: four-lane pipelined restoring divider, one quotient bit per stage
// computes floor(mag * 2^16 / div) per lane; uses mwm_pkg
module mwm_div_pipe
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mwm_pkg::lane_ctl_t    in_ctl,
    input  mwm_pkg::mag_lanes_t   in_mag,
    input  mwm_pkg::mag_t         in_div,
    output logic                  up_hold,
    input  logic                  down_hold,
    output mwm_pkg::lane_ctl_t    out_ctl,
    output mwm_pkg::quo_lanes_t   out_quo
);

    localparam int LAST = mwm_pkg::DIV_STEPS - 1;

    logic [mwm_pkg::DIV_STEPS-1:0]  valid_reg;
    logic [mwm_pkg::DIV_STEPS:0]    hold;
    logic [mwm_pkg::LANES-1:0]      neg_reg [mwm_pkg::DIV_STEPS];
    mwm_pkg::mag_lanes_t            rem_reg [mwm_pkg::DIV_STEPS];
    mwm_pkg::quo_lanes_t            quo_reg [mwm_pkg::DIV_STEPS];
    mwm_pkg::mag_t                  div_reg [mwm_pkg::DIV_STEPS];

    // a stage holds when it is full and the stage after it holds
    assign hold[mwm_pkg::DIV_STEPS] = down_hold;
    assign up_hold = hold[0];

    for (genvar j = 0; j < mwm_pkg::DIV_STEPS; j++)
    begin : g_step
        logic                      src_valid;
        logic [mwm_pkg::LANES-1:0] src_neg;
        mwm_pkg::mag_t             src_div;
        logic [mwm_pkg::MAG_W:0]   trial [mwm_pkg::LANES];
        mwm_pkg::quo_lanes_t       src_quo;
        mwm_pkg::mag_lanes_t       rem_next;
        mwm_pkg::quo_lanes_t       quo_next;

        assign hold[j] = valid_reg[j] && hold[j+1];

        // source of this step: the input port or the previous stage
        if (j == 0)
        begin : g_first
            assign src_valid = in_ctl.valid;
            assign src_neg   = in_ctl.neg;
            assign src_div   = in_div;
            assign src_quo   = '0;
            for (genvar k = 0; k < mwm_pkg::LANES; k++)
            begin : g_lane
                assign trial[k] = {1'b0, in_mag[k]};
            end
        end
        else
        begin : g_next
            assign src_valid = valid_reg[j-1];
            assign src_neg   = neg_reg[j-1];
            assign src_div   = div_reg[j-1];
            assign src_quo   = quo_reg[j-1];
            for (genvar k = 0; k < mwm_pkg::LANES; k++)
            begin : g_lane
                assign trial[k] = {rem_reg[j-1][k], 1'b0};
            end
        end

        // one compare and subtract per lane
        for (genvar k = 0; k < mwm_pkg::LANES; k++)
        begin : g_cmp
            logic                    fits;
            logic [mwm_pkg::MAG_W:0] diff;

            assign diff = trial[k] - {1'b0, src_div};
            assign fits = trial[k] >= {1'b0, src_div};
            assign rem_next[k] = fits ? diff[mwm_pkg::MAG_W-1:0]
                                      : trial[k][mwm_pkg::MAG_W-1:0];
            assign quo_next[k] = {src_quo[k][mwm_pkg::QUO_W-2:0], fits};
        end

        // stage valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (!hold[j])
            begin
                valid_reg[j] <= src_valid;
            end
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            if (!hold[j] && src_valid)
            begin
                neg_reg[j] <= src_neg;
                div_reg[j] <= src_div;
                rem_reg[j] <= rem_next;
                quo_reg[j] <= quo_next;
            end
        end
    end

    assign out_ctl.valid = valid_reg[LAST];
    assign out_ctl.neg   = neg_reg[LAST];
    assign out_quo       = quo_reg[LAST];

`include "mecanum_wheel_mixer_assert.svh"

    // every remainder stays below the divisor
    `MWM_ASSERT_IMP(a_rem_below_div, valid_reg[LAST], (rem_reg[LAST][0] < div_reg[LAST]) && (rem_reg[LAST][1] < div_reg[LAST]) && (rem_reg[LAST][2] < div_reg[LAST]) && (rem_reg[LAST][3] < div_reg[LAST]))

    // magnitudes never exceed the divisor, so the quotient is bounded
    `MWM_ASSERT_IMP(a_quo_bound, valid_reg[LAST], (quo_reg[LAST][0] <= mwm_pkg::QUO_LIMIT) && (quo_reg[LAST][1] <= mwm_pkg::QUO_LIMIT) && (quo_reg[LAST][2] <= mwm_pkg::QUO_LIMIT) && (quo_reg[LAST][3] <= mwm_pkg::QUO_LIMIT))

    // a request leaving the first step lands in the second
    `MWM_ASSERT_NXT(a_step_moves, valid_reg[0] && !hold[1], valid_reg[1])

endmodule

@@ hdl/mecanum_wheel_mixer.sv @@
// mecanum_wheel_mixer: mecanum inverse kinematics with normalization to unit speed
// uses mwm_pkg and mwm_div_pipe
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   in      | in_valid / in_stall  | vel_x, vel_y, turn_rate (signed Q4.12)
//   out     | out_valid / out_stall| front_left, front_right, back_left,
//           |                      | back_right (signed Q1.15)
//
// one request per cycle while in_stall is low
// pipeline: 6 mix/max stages, 17 divider steps (one quotient bit each), 1 round stage
// reset clears only the valid bits; no clearing pass, the block is ready at once
// each stage holds only while full and blocked, so bubbles close up under out_stall
// in_stall rises only when every stage is full behind a stalled result
module mecanum_wheel_mixer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [mwm_pkg::IN_W-1:0]    vel_x,
    input  logic signed [mwm_pkg::IN_W-1:0]    vel_y,
    input  logic signed [mwm_pkg::IN_W-1:0]    turn_rate,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [mwm_pkg::OUT_W-1:0]   front_left,
    output logic signed [mwm_pkg::OUT_W-1:0]   front_right,
    output logic signed [mwm_pkg::OUT_W-1:0]   back_left,
    output logic signed [mwm_pkg::OUT_W-1:0]   back_right
);

    // stage valid bits and hold chain
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic out_valid_reg;
    logic s1_hold, s2_hold, s3_hold, s4_hold, s5_hold, s6_hold;
    logic div_hold, out_hold;

    // stage 1: y - x, y + x
    logic signed [mwm_pkg::SUM_W-1:0]  diff_next, sum_next;
    logic signed [mwm_pkg::SUM_W-1:0]  diff_reg, sum_reg;
    logic signed [mwm_pkg::IN_W-1:0]   turn1_reg;

    // stage 2: products with 1/sqrt2
    logic signed [mwm_pkg::RAW_W-1:0]  a_next, b_next;
    logic signed [mwm_pkg::RAW_W-1:0]  a_reg, b_reg;
    logic signed [mwm_pkg::IN_W-1:0]   turn2_reg;

    // stage 3: raw wheel speeds in Q.42
    logic signed [mwm_pkg::RAW_W-1:0]  wq;
    logic signed [mwm_pkg::RAW_W-1:0]  raw_next [mwm_pkg::LANES];
    logic signed [mwm_pkg::RAW_W-1:0]  raw_reg  [mwm_pkg::LANES];

    // stage 4: magnitudes and signs
    mwm_pkg::mag_lanes_t               mag4_next, mag4_reg;
    logic [mwm_pkg::LANES-1:0]         neg4_next, neg4_reg;

    // stage 5: pairwise maxima
    mwm_pkg::mag_lanes_t               mag5_reg;
    logic [mwm_pkg::LANES-1:0]         neg5_reg;
    mwm_pkg::mag_t                     max01_next, max23_next;
    mwm_pkg::mag_t                     max01_reg, max23_reg;

    // stage 6: divisor
    mwm_pkg::mag_lanes_t               mag6_reg;
    logic [mwm_pkg::LANES-1:0]         neg6_reg;
    mwm_pkg::mag_t                     max_all, div6_next, div6_reg;

    // divider interface
    mwm_pkg::lane_ctl_t                div_in_ctl, div_out_ctl;
    mwm_pkg::quo_lanes_t               div_quo;

    // output stage
    logic [mwm_pkg::OUT_W-1:0]         wheel_next [mwm_pkg::LANES];
    logic [mwm_pkg::OUT_W-1:0]         wheel_reg  [mwm_pkg::LANES];

    // hold chain from the output back to the input
    assign out_hold = out_valid_reg && out_stall;
    assign s6_hold  = s6_valid_reg && div_hold;
    assign s5_hold  = s5_valid_reg && s6_hold;
    assign s4_hold  = s4_valid_reg && s5_hold;
    assign s3_hold  = s3_valid_reg && s4_hold;
    assign s2_hold  = s2_valid_reg && s3_hold;
    assign s1_hold  = s1_valid_reg && s2_hold;
    assign in_stall = s1_hold;

    // mix sums, exact in 17 bits
    assign diff_next = mwm_pkg::SUM_W'(vel_y) - mwm_pkg::SUM_W'(vel_x);
    assign sum_next  = mwm_pkg::SUM_W'(vel_y) + mwm_pkg::SUM_W'(vel_x);

    // scale by 1/sqrt2 into Q.42; sign-extended operands, a 17 x 31 bit product
    assign a_next = mwm_pkg::RAW_W'(diff_reg) * mwm_pkg::RAW_W'(mwm_pkg::INV_SQRT2_Q30);
    assign b_next = mwm_pkg::RAW_W'(sum_reg) * mwm_pkg::RAW_W'(mwm_pkg::INV_SQRT2_Q30);

    // turn rate into Q.42 and the four raw speeds
    assign wq = {{(mwm_pkg::RAW_W-mwm_pkg::IN_W-mwm_pkg::W_SHIFT){turn2_reg[mwm_pkg::IN_W-1]}},
                 turn2_reg, {mwm_pkg::W_SHIFT{1'b0}}};
    assign raw_next[0] = a_reg - wq;
    assign raw_next[1] = b_reg + wq;
    assign raw_next[2] = b_reg - wq;
    assign raw_next[3] = a_reg + wq;

    // magnitude and sign per wheel
    for (genvar k = 0; k < mwm_pkg::LANES; k++)
    begin : g_mag
        logic [mwm_pkg::RAW_W-1:0] abs_val;

        assign neg4_next[k] = raw_reg[k][mwm_pkg::RAW_W-1];
        assign abs_val      = neg4_next[k] ? (~raw_reg[k] + mwm_pkg::RAW_W'(1)) : raw_reg[k];
        assign mag4_next[k] = abs_val[mwm_pkg::MAG_W-1:0];
    end

    // greatest magnitude, never below 1.0
    assign max01_next = (mag4_reg[0] >= mag4_reg[1]) ? mag4_reg[0] : mag4_reg[1];
    assign max23_next = (mag4_reg[2] >= mag4_reg[3]) ? mag4_reg[2] : mag4_reg[3];
    assign max_all    = (max01_reg >= max23_reg) ? max01_reg : max23_reg;
    assign div6_next  = (max_all > mwm_pkg::ONE_Q42) ? max_all : mwm_pkg::ONE_Q42;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_hold)
            begin
                s1_valid_reg <= in_valid;
            end
            if (!s2_hold)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (!s3_hold)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (!s4_hold)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (!s5_hold)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (!s6_hold)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
            if (!out_hold)
            begin
                out_valid_reg <= div_out_ctl.valid;
            end
        end
    end

    // stage payloads, loaded only with a valid request
    always_ff @(posedge clk)
    begin
        if (!s1_hold && in_valid)
        begin
            diff_reg  <= diff_next;
            sum_reg   <= sum_next;
            turn1_reg <= turn_rate;
        end
        if (!s2_hold && s1_valid_reg)
        begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            turn2_reg <= turn1_reg;
        end
        if (!s3_hold && s2_valid_reg)
        begin
            raw_reg <= raw_next;
        end
        if (!s4_hold && s3_valid_reg)
        begin
            mag4_reg <= mag4_next;
            neg4_reg <= neg4_next;
        end
        if (!s5_hold && s4_valid_reg)
        begin
            mag5_reg  <= mag4_reg;
            neg5_reg  <= neg4_reg;
            max01_reg <= max01_next;
            max23_reg <= max23_next;
        end
        if (!s6_hold && s5_valid_reg)
        begin
            mag6_reg <= mag5_reg;
            neg6_reg <= neg5_reg;
            div6_reg <= div6_next;
        end
        if (!out_hold && div_out_ctl.valid)
        begin
            wheel_reg <= wheel_next;
        end
    end

    // divider: floor(|raw| * 2^16 / divisor) per wheel
    assign div_in_ctl.valid = s6_valid_reg;
    assign div_in_ctl.neg   = neg6_reg;

    mwm_div_pipe u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (div_in_ctl),
        .in_mag    (mag6_reg),
        .in_div    (div6_reg),
        .up_hold   (div_hold),
        .down_hold (out_hold),
        .out_ctl   (div_out_ctl),
        .out_quo   (div_quo)
    );

    // round half up, apply sign, saturate +1.0
    for (genvar k = 0; k < mwm_pkg::LANES; k++)
    begin : g_round
        logic [mwm_pkg::QUO_W:0]   rnd_sum;
        logic [mwm_pkg::QUO_W-1:0] rnd_q;
        logic [mwm_pkg::OUT_W-1:0] q_low;

        assign rnd_sum = {1'b0, div_quo[k]} + (mwm_pkg::QUO_W+1)'(1);
        assign rnd_q   = rnd_sum[mwm_pkg::QUO_W:1];
        assign q_low   = rnd_q[mwm_pkg::OUT_W-1:0];

        always_comb
        begin
            if (div_out_ctl.neg[k])
            begin
                wheel_next[k] = ~q_low + mwm_pkg::OUT_W'(1);
            end
            else if (rnd_q > mwm_pkg::QUO_W'(mwm_pkg::OUT_MAX))
            begin
                wheel_next[k] = mwm_pkg::OUT_MAX;
            end
            else
            begin
                wheel_next[k] = q_low;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign front_left  = $signed(wheel_reg[0]);
    assign front_right = $signed(wheel_reg[1]);
    assign back_left   = $signed(wheel_reg[2]);
    assign back_right  = $signed(wheel_reg[3]);

`include "mecanum_wheel_mixer_assert.svh"

    // the divisor is never below 1.0
    `MWM_ASSERT_IMP(a_div_floor, s6_valid_reg, div6_reg >= mwm_pkg::ONE_Q42)

    // no wheel magnitude exceeds the divisor
    `MWM_ASSERT_IMP(a_mag_in_div, s6_valid_reg,
        (mag6_reg[0] <= div6_reg) && (mag6_reg[1] <= div6_reg) &&
        (mag6_reg[2] <= div6_reg) && (mag6_reg[3] <= div6_reg))

    // a request not held in stage 1 moves into stage 2
    `MWM_ASSERT_NXT(a_s1_moves, s1_valid_reg && !s2_hold, s2_valid_reg)

endmodule
